FILE: sv/etcb_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler-to-camera-basis block.
package etcb_pkg;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam int          NSLOT   = 5;
  localparam int          NSTG    = 3 * NSLOT;

  // Horner divisors per slot; sine is idle in slot 0 (its entry there is unused)
  localparam int COS_DIV [NSLOT] = '{90, 56, 30, 12, 2};
  localparam int SIN_DIV [NSLOT] = '{2, 72, 42, 20, 6};

  localparam int TDATA_W = 144;

  // classified angle: octant and reflected offset within the octant
  typedef struct packed {
    logic [2:0]  oct;
    logic [29:0] off;
  } etcb_ang_t;

  typedef struct packed {
    etcb_ang_t          az;
    etcb_ang_t          ay;
    etcb_ang_t          ax;
    logic signed [31:0] oz;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
  } etcb_item_t;

  typedef struct packed {
    logic [2:0]  oct;
    logic [29:0] r;
    logic [29:0] r2;
    logic [30:0] tc;
    logic [30:0] ts;
    logic [29:0] pc;
    logic [29:0] ps;
    logic [29:0] qc;
    logic [29:0] qs;
  } etcb_lane_t;

  // signed Q1.30 product, rounded half away from zero
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] q;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    p  = 62'(ma) * 62'(mb);
    q  = 32'((p + 62'(32'h2000_0000)) >> 30);
    return (a[31] ^ b[31]) ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: sv/etcb_front.sv
// Input side: unpacks a transaction and folds each angle into octant and offset.
module etcb_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic [etcb_pkg::TDATA_W-1:0] in_tdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         q_full,
  output logic                         q_push,
  output etcb_pkg::etcb_item_t         q_item
);

  function automatic etcb_pkg::etcb_ang_t classify(input logic [15:0] ang);
    logic [31:0] a32;
    logic [31:0] ph;
    etcb_pkg::etcb_ang_t res;
    a32 = {16'b0, ang} & ((32'd1 << ANGLE_BITS) - 32'd1);
    ph  = a32 << (32 - ANGLE_BITS);
    res.oct = ph[31:29];
    res.off = ph[29] ? (30'h2000_0000 - {1'b0, ph[28:0]}) : {1'b0, ph[28:0]};
    return res;
  endfunction

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.ax = classify(in_tdata[15:0]);
    q_item.ay = classify(in_tdata[31:16]);
    q_item.az = classify(in_tdata[47:32]);
    q_item.ox = $signed(in_tdata[79:48]);
    q_item.oy = $signed(in_tdata[111:80]);
    q_item.oz = $signed(in_tdata[143:112]);
  end

endmodule

FILE: sv/etcb_fifo.sv
// Four-entry queue between the input side and the arithmetic pipeline.
module etcb_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  etcb_pkg::etcb_item_t wr_item,
  input  logic                 pop,
  output etcb_pkg::etcb_item_t rd_item,
  output logic                 full,
  output logic                 empty
);

  etcb_pkg::etcb_item_t mem [4];
  logic [1:0] wptr_r;
  logic [1:0] rptr_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_item = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 2'd1;
      if (pop)  rptr_r <= rptr_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: sv/etcb_lane.sv
// One sine/cosine lane: Taylor series by Horner steps, three stages per step.
module etcb_lane (
  input  logic                clk,
  input  logic                en,
  input  etcb_pkg::etcb_ang_t ang,
  output logic signed [31:0]  sn,
  output logic signed [31:0]  cs
);

  logic [2:0]  oct0_r;
  logic [29:0] r0_r;
  etcb_pkg::etcb_lane_t st [0:etcb_pkg::NSTG];
  logic [2:0]  octf_r;
  logic [29:0] sf_r;
  logic [30:0] cf_r;
  logic signed [31:0] sn_r;
  logic signed [31:0] cs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      oct0_r <= ang.oct;
      r0_r   <= 30'((60'(ang.off) * 60'(etcb_pkg::PI4_Q30)) >> 29);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].oct <= oct0_r;
      st[0].r   <= r0_r;
      st[0].r2  <= 30'((60'(r0_r) * 60'(r0_r)) >> 30);
      st[0].tc  <= etcb_pkg::Q30_ONE;
      st[0].ts  <= etcb_pkg::Q30_ONE;
      st[0].pc  <= '0;
      st[0].ps  <= '0;
      st[0].qc  <= '0;
      st[0].qs  <= '0;
    end
  end

  for (genvar i = 0; i < etcb_pkg::NSTG; i++) begin : g_stg
    localparam int SL = i / 3;
    localparam int KD = i % 3;
    localparam int DC = etcb_pkg::COS_DIV[SL];
    localparam int DS = etcb_pkg::SIN_DIV[SL];
    localparam int SC = 30 + $clog2(DC);
    localparam int SS = 30 + $clog2(DS);
    localparam logic [30:0] MC = 31'((64'd1 << SC) / DC);
    localparam logic [30:0] MS = 31'((64'd1 << SS) / DS);
    etcb_pkg::etcb_lane_t nx;
    logic [36:0] remc;
    logic [36:0] rems;

    always_comb begin
      nx   = st[i];
      remc = 37'(st[i].pc) - 37'(st[i].qc) * 37'(DC);
      rems = 37'(st[i].ps) - 37'(st[i].qs) * 37'(DS);
      case (KD)
        0: begin
          nx.pc = 30'((61'(st[i].r2) * 61'(st[i].tc)) >> 30);
          nx.ps = 30'((61'(st[i].r2) * 61'(st[i].ts)) >> 30);
        end
        1: begin
          nx.qc = 30'((61'(st[i].pc) * 61'(MC)) >> SC);
          nx.qs = 30'((61'(st[i].ps) * 61'(MS)) >> SS);
        end
        default: begin
          nx.tc = etcb_pkg::Q30_ONE - 31'(st[i].qc + 30'(remc >= 37'(DC)));
          if (SL == 0) begin
            nx.ts = etcb_pkg::Q30_ONE;
          end else begin
            nx.ts = etcb_pkg::Q30_ONE - 31'(st[i].qs + 30'(rems >= 37'(DS)));
          end
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) st[i+1] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      octf_r <= st[etcb_pkg::NSTG].oct;
      sf_r   <= 30'((61'(st[etcb_pkg::NSTG].r) * 61'(st[etcb_pkg::NSTG].ts)) >> 30);
      cf_r   <= st[etcb_pkg::NSTG].tc;
    end
  end

  logic signed [31:0] sb;
  logic signed [31:0] cb;

  always_comb begin
    if (octf_r[0]) begin
      sb = $signed({1'b0, cf_r});
      cb = $signed({2'b0, sf_r});
    end else begin
      sb = $signed({2'b0, sf_r});
      cb = $signed({1'b0, cf_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (octf_r[2:1])
        2'd0:    begin sn_r <= sb;  cs_r <= cb;  end
        2'd1:    begin sn_r <= cb;  cs_r <= -sb; end
        2'd2:    begin sn_r <= -sb; cs_r <= -cb; end
        default: begin sn_r <= -cb; cs_r <= sb;  end
      endcase
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule

FILE: sv/etcb_back.sv
// Arithmetic side: three sine/cosine lanes, matrix products and output register.
module etcb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  etcb_pkg::etcb_item_t         q_item,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic [etcb_pkg::TDATA_W-1:0] out_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready
);

  localparam int LAT = 23;
  localparam int ODLY = 22;

  logic en;
  logic [LAT-1:0] vld_r;
  logic signed [31:0] org_r [0:ODLY-1][0:2];
  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  assign en    = !vld_r[LAT-1] || out_tready;
  assign q_pop = en && !q_empty;

  etcb_lane u_lx (.clk(clk), .en(en), .ang(q_item.ax), .sn(sx), .cs(cx));
  etcb_lane u_ly (.clk(clk), .en(en), .ang(q_item.ay), .sn(sy), .cs(cy));
  etcb_lane u_lz (.clk(clk), .en(en), .ang(q_item.az), .sn(sz), .cs(cz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      org_r[0][0] <= q_item.ox;
      org_r[0][1] <= q_item.oy;
      org_r[0][2] <= q_item.oz;
      for (int k = 1; k < ODLY; k++) begin
        org_r[k] <= org_r[k-1];
      end
    end
  end

  // stage 1: shared sub-products
  logic signed [31:0] syx_r, syc_r, sx1_r, cx1_r, sz1_r, cz1_r, cy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      syx_r <= etcb_pkg::mul_q30(sy, sx);
      syc_r <= etcb_pkg::mul_q30(sy, cx);
      sx1_r <= sx;
      cx1_r <= cx;
      sz1_r <= sz;
      cz1_r <= cz;
      cy1_r <= cy;
    end
  end

  // stage 2: matrix entries
  logic signed [31:0] t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r, t8_r, fz2_r, uz2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= etcb_pkg::mul_q30(cz1_r, syc_r);
      t2_r  <= etcb_pkg::mul_q30(sz1_r, sx1_r);
      t3_r  <= etcb_pkg::mul_q30(sz1_r, syc_r);
      t4_r  <= etcb_pkg::mul_q30(cz1_r, sx1_r);
      t5_r  <= etcb_pkg::mul_q30(cz1_r, syx_r);
      t6_r  <= etcb_pkg::mul_q30(sz1_r, cx1_r);
      t7_r  <= etcb_pkg::mul_q30(sz1_r, syx_r);
      t8_r  <= etcb_pkg::mul_q30(cz1_r, cx1_r);
      fz2_r <= -etcb_pkg::mul_q30(cy1_r, cx1_r);
      uz2_r <= etcb_pkg::mul_q30(cy1_r, sx1_r);
    end
  end

  // stage 3: forward and up vectors, Q1.30
  logic signed [33:0] fx_r, fy_r, fz_r, ux_r, uy_r, uz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fx_r <= -(34'(t1_r) + 34'(t2_r));
      fy_r <= -(34'(t3_r) - 34'(t4_r));
      fz_r <= 34'(fz2_r);
      ux_r <= 34'(t5_r) - 34'(t6_r);
      uy_r <= 34'(t7_r) + 34'(t8_r);
      uz_r <= 34'(uz2_r);
    end
  end

  function automatic logic [31:0] center_of(input logic signed [31:0] o,
                                            input logic signed [33:0] f);
    logic [33:0] m;
    logic [19:0] r;
    logic signed [33:0] sv;
    logic signed [33:0] sum;
    logic [31:0] res;
    m   = f[33] ? 34'(-f) : f;
    r   = 20'((m + 34'd8192) >> 14);
    sv  = f[33] ? -$signed(34'(r)) : $signed(34'(r));
    sum = 34'(o) + sv;
    if (sum > 34'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] up_of(input logic signed [33:0] u);
    logic [33:0] m;
    logic [17:0] r;
    logic [15:0] res;
    m = u[33] ? 34'(-u) : u;
    r = 18'((m + 34'd32768) >> 16);
    if (r > 18'd16384) r = 18'd16384;
    res = u[33] ? 16'(-r) : 16'(r);
    return res;
  endfunction

  // stage 4: rounding, saturation and output register
  logic [etcb_pkg::TDATA_W-1:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r[31:0]    <= center_of(org_r[ODLY-1][0], fx_r);
      out_r[63:32]   <= center_of(org_r[ODLY-1][1], fy_r);
      out_r[95:64]   <= center_of(org_r[ODLY-1][2], fz_r);
      out_r[111:96]  <= up_of(ux_r);
      out_r[127:112] <= up_of(uy_r);
      out_r[143:128] <= up_of(uz_r);
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = vld_r[LAT-1];

endmodule

FILE: sv/euler_to_camera_basis_top.sv
// Throughput: one transaction per cycle, fully pipelined; the pipeline advances whenever
//   the output register is empty or being taken.
// A four-entry queue decouples input acceptance from pipeline stalls.
// Reset (rst_n low, synchronous) empties the queue and clears all valid flags.
module euler_to_camera_basis_top #(
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // angle_x[15:0], angle_y[31:16], angle_z[47:32],
  // origin_x[79:48], origin_y[111:80], origin_z[143:112]
  input  logic [143:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64],
  // up_x[111:96], up_y[127:112], up_z[143:128]
  output logic [143:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready
);

  // front -> queue: classified transaction (octant, folded offset, eye position)
  etcb_pkg::etcb_item_t push_item;
  etcb_pkg::etcb_item_t pop_item;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  etcb_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  etcb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (pop_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: sine/cosine lanes, rotation products, centre/up rounding
  etcb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (pop_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

FILE: verif/tb_euler_to_camera_basis_top.sv
// Testbench for euler_to_camera_basis_top: directed and random camera poses checked against a predictor.
`timescale 1ns / 1ps

// Scoreboard: predicts the camera basis per input transaction and checks results in order.
class basis_scoreboard;
  logic [143:0] basis_q[$];
  int           n_err;
  int           n_in;
  int           n_out;

  function new();
    n_err = 0;
    n_in  = 0;
    n_out = 0;
  endfunction

  // signed Q1.30 multiply, rounded half away from zero
  static function longint qmul(longint a, longint b);
    longint ma;
    longint mb;
    longint p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p  = (ma * mb + (64'sd1 <<< 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  static function longint rshift_round(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  // Horner series for sin and cos on [0, pi/4], unsigned Q1.30
  static function void base_trig(longint r, output longint s, output longint c);
    longint r2;
    longint t;
    longint one;
    one = 64'sd1 <<< 30;
    r2  = (r * r) >>> 30;
    t = one;
    t = one - ((r2 * t) >>> 30) / 72;
    t = one - ((r2 * t) >>> 30) / 42;
    t = one - ((r2 * t) >>> 30) / 20;
    t = one - ((r2 * t) >>> 30) / 6;
    s = (r * t) >>> 30;
    t = one;
    t = one - ((r2 * t) >>> 30) / 90;
    t = one - ((r2 * t) >>> 30) / 56;
    t = one - ((r2 * t) >>> 30) / 30;
    t = one - ((r2 * t) >>> 30) / 12;
    t = one - ((r2 * t) >>> 30) / 2;
    c = t;
  endfunction

  static function void angle_trig(logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] phase;
    logic [2:0]  oct;
    longint      f;
    longint      s;
    longint      c;
    longint      sb;
    longint      cb;
    phase = {ang, 16'h0};
    oct   = phase[31:29];
    f     = phase[28:0];
    if (oct[0]) f = (64'sd1 <<< 29) - f;
    base_trig((f * 64'sd843314857) >>> 29, s, c);
    sb = oct[0] ? c : s;
    cb = oct[0] ? s : c;
    case (oct[2:1])
      2'd0: begin sn = sb;  cs = cb;  end
      2'd1: begin sn = cb;  cs = -sb; end
      2'd2: begin sn = -sb; cs = -cb; end
      default: begin sn = -cb; cs = sb; end
    endcase
  endfunction

  static function logic [31:0] centre_sat(logic signed [31:0] eye, longint fwd);
    longint v;
    v = longint'(eye) + rshift_round(fwd, 14);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  static function logic [15:0] up_clamp(longint u);
    longint v;
    v = rshift_round(u, 16);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  // note an accepted input transaction
  function void note_pose(logic [143:0] d);
    longint sx, cx, sy, cy, sz, cz, syx, syc, fx, fy, fz, ux, uy, uz;
    angle_trig(d[15:0], sx, cx);
    angle_trig(d[31:16], sy, cy);
    angle_trig(d[47:32], sz, cz);
    syx = qmul(sy, sx);
    syc = qmul(sy, cx);
    fx  = -(qmul(cz, syc) + qmul(sz, sx));
    fy  = -(qmul(sz, syc) - qmul(cz, sx));
    fz  = -qmul(cy, cx);
    ux  = qmul(cz, syx) - qmul(sz, cx);
    uy  = qmul(sz, syx) + qmul(cz, cx);
    uz  = qmul(cy, sx);
    basis_q.push_back({up_clamp(uz), up_clamp(uy), up_clamp(ux),
                       centre_sat(d[143:112], fz), centre_sat(d[111:80], fy),
                       centre_sat(d[79:48], fx)});
    n_in++;
  endfunction

  function void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      n_err++;
    end
  endfunction

  // check one result transaction against the oldest prediction
  function void check_basis(logic [143:0] r);
    logic [143:0] e;
    n_out++;
    if (basis_q.size() == 0) begin
      $error("unexpected result %h", r);
      n_err++;
      return;
    end
    e = basis_q.pop_front();
    cmp("center_x", e[31:0], r[31:0]);
    cmp("center_y", e[63:32], r[63:32]);
    cmp("center_z", e[95:64], r[95:64]);
    cmp("up_x", {16'h0, e[111:96]}, {16'h0, r[111:96]});
    cmp("up_y", {16'h0, e[127:112]}, {16'h0, r[127:112]});
    cmp("up_z", {16'h0, e[143:128]}, {16'h0, r[143:128]});
  endfunction
endclass

module tb_euler_to_camera_basis_top;
  logic         clk;
  logic         rst_n;
  logic [143:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;

  basis_scoreboard sb;
  int              gap_mode;

  euler_to_camera_basis_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, sometimes none for a stretch, rarely long
  function automatic int pick_gap();
    if (gap_mode == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // present one pose and hold it until the transaction completes
  task automatic send_pose(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= {oz, oy, ox, az, ay, ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    // the handshake just took place at this edge
    sb.note_pose({oz, oy, ox, az, ay, ax});
  endtask

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 70000);
      1: return 32'h8000_0000 + $urandom_range(0, 70000);
      2: return $urandom_range(0, 65536 * 8) - 32'd262144;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 7)) << 13;                        // octant edge
      1: return (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random back-pressure, check on every handshake
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid) sb.check_basis(out_tdata);
    end
  end

  // stimulus
  initial begin
    logic [15:0] ext [8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
                             16'h8000, 16'hA000, 16'hC000, 16'hFFFF};
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    gap_mode  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: octant boundaries, all-ones angles, saturating eyes
    for (int i = 0; i < 8; i++)
      send_pose(ext[i], ext[(i + 3) % 8], ext[(i + 5) % 8], 32'h0, 32'h0001_0000, 32'hFFFF_0000);
    send_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pose(16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pose(16'h0000, 16'h0000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pose(16'h1000, 16'h3000, 16'h5000, 32'h7FFF_0000, 32'h8000_FFFF, 32'hFFFF_FFFF);
    send_pose(16'h5555, 16'hAAAA, 16'h0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001);
    send_pose(16'hAAAA, 16'h5555, 16'hFFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE);

    // random: alternate stretches with and without idling
    for (int i = 0; i < 1300; i++) begin
      if (i % 100 == 0) gap_mode = $urandom_range(0, 2);
      send_pose(rand_angle(), rand_angle(), rand_angle(),
                rand_origin(), rand_origin(), rand_origin());
    end
    in_tvalid <= 1'b0;

    while (sb.basis_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d poses, %0d results checked (octant edges, saturation, wrap).",
             sb.n_in, sb.n_out);
    if (sb.n_err == 0)
      $display("euler_to_camera_basis_top verification clean");
    else
      $display("euler_to_camera_basis_top verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("euler_to_camera_basis_top verification failed");
    $finish;
  end
endmodule
